[design/bla_pkg.sv]
package bla_pkg;

  typedef logic [8:0] angle_t;
  typedef logic [7:0] speed_t;

  localparam angle_t FULL_TURN    = 9'd360;
  localparam angle_t HALF_TURN    = 9'd180;
  localparam angle_t QUARTER_TURN = 9'd90;
  localparam angle_t NEAR_LIMIT   = 9'd60;
  localparam angle_t REFLEX_LIMIT = FULL_TURN - QUARTER_TURN;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    LS_ON_FIELD = 2'd0,
    LS_TOUCHING = 2'd1,
    LS_OVER     = 2'd2,
    LS_OUT      = 2'd3
  } line_state_t;

  typedef enum logic {
    CFG_SLOW_SPEED = 1'b0,
    CFG_FAST_SPEED = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic   seen;
    angle_t line_abs;
    angle_t heading;
    angle_t proposed_direction;
    speed_t proposed_speed;
  } bla_item_t;

  typedef struct packed {
    angle_t      move_direction;
    speed_t      move_speed;
    logic        inside_field;
    line_state_t crossing_state;
  } bla_result_t;

endpackage

[design/boundary_line_avoidance.sv]
// Channel  | Dir | tdata / tuser
// s_axis   | in  | tuser: line_seen; tdata: line_direction, heading,
//          |     |   proposed_direction, proposed_speed
// m_axis   | out | tdata: move_direction, move_speed, inside_field, crossing_state
// cfg      | in  | cfg_we, cfg_index (0 slow speed, 1 fast speed), cfg_data
//
// One beat per cycle unless m_tready stalls; path: input register, then result register.
// Crossing state updates as an item moves from the input register to the result register.
// Synchronous reset restores on-field state and clears both speeds.
// A stall on m_tready holds the result register and a full input register; s_tready drops.
module boundary_line_avoidance (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [8:0] line_direction, [17:9] heading, [26:18] proposed_direction,
  // [34:27] proposed_speed, [39:35] zero
  input  logic [bla_pkg::IN_DATA_W-1:0] s_tdata,
  // [0] line_seen
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [8:0] move_direction, [16:9] move_speed, [17] inside_field,
  // [19:18] crossing_state, [23:20] zero
  output logic [bla_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic                 stage_valid;
  logic                 out_adv;
  logic                 in_acc;
  bla_pkg::bla_item_t   item;
  bla_pkg::bla_result_t result;
  bla_pkg::cfg_index_t  cfg_sel;

  assign out_adv  = !m_tvalid || m_tready;
  assign s_tready = !stage_valid || out_adv;
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_sel  = bla_pkg::cfg_index_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (s_tready) begin
        stage_valid <= s_tvalid;
      end
      if (out_adv) begin
        m_tvalid <= stage_valid;
      end
    end
  end

  bla_prep u_prep (
    .clk                (clk),
    .load               (in_acc),
    .line_seen          (s_tuser),
    .line_direction     (s_tdata[8:0]),
    .heading            (s_tdata[17:9]),
    .proposed_direction (s_tdata[26:18]),
    .proposed_speed     (s_tdata[34:27]),
    .item               (item)
  );

  bla_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_sel),
    .cfg_data  (cfg_data),
    .load      (stage_valid && out_adv),
    .item      (item),
    .result    (result)
  );

  assign m_tdata = {4'b0000, result.crossing_state, result.inside_field,
                    result.move_speed, result.move_direction};

endmodule

[design/bla_prep.sv]
module bla_prep (
  input  logic               clk,
  input  logic               load,
  input  logic               line_seen,
  input  bla_pkg::angle_t    line_direction,
  input  bla_pkg::angle_t    heading,
  input  bla_pkg::angle_t    proposed_direction,
  input  bla_pkg::speed_t    proposed_speed,
  output bla_pkg::bla_item_t item
);

  bla_pkg::angle_t   head_w;
  bla_pkg::angle_t   pdir_w;
  logic [9:0]        line_sum;
  logic [9:0]        full_10;
  logic [9:0]        line_mod;
  bla_pkg::bla_item_t item_next;

  assign full_10 = {1'b0, bla_pkg::FULL_TURN};

  always_comb begin
    head_w = (heading >= bla_pkg::FULL_TURN) ? heading - bla_pkg::FULL_TURN : heading;
    pdir_w = (proposed_direction >= bla_pkg::FULL_TURN) ?
             proposed_direction - bla_pkg::FULL_TURN : proposed_direction;
    line_sum = {1'b0, line_direction} + {1'b0, head_w};
    if (line_sum >= (full_10 << 1)) begin
      line_mod = line_sum - (full_10 << 1);
    end else if (line_sum >= full_10) begin
      line_mod = line_sum - full_10;
    end else begin
      line_mod = line_sum;
    end
    item_next.seen               = line_seen;
    item_next.line_abs           = line_mod[8:0];
    item_next.heading            = head_w;
    item_next.proposed_direction = pdir_w;
    item_next.proposed_speed     = proposed_speed;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_next;
    end
  end

endmodule

[design/bla_track.sv]
module bla_track (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  bla_pkg::cfg_index_t  cfg_index,
  input  bla_pkg::speed_t      cfg_data,
  input  logic                 load,
  input  bla_pkg::bla_item_t   item,
  output bla_pkg::bla_result_t result
);

  bla_pkg::speed_t      slow_speed;
  bla_pkg::speed_t      fast_speed;
  logic                 on_field;
  bla_pkg::angle_t      angle;
  bla_pkg::line_state_t line_state;

  logic                 on_field_next;
  bla_pkg::angle_t      angle_next;
  bla_pkg::line_state_t line_state_next;
  bla_pkg::bla_result_t result_next;

  bla_pkg::angle_t      gap;
  logic                 close;
  bla_pkg::angle_t      line_opp;
  bla_pkg::angle_t      flip;
  logic [9:0]           away_sum;
  bla_pkg::angle_t      away;
  bla_pkg::angle_t      diff;
  logic                 near;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_speed <= '0;
      fast_speed <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bla_pkg::CFG_SLOW_SPEED: slow_speed <= cfg_data;
        bla_pkg::CFG_FAST_SPEED: fast_speed <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    gap = (item.line_abs >= angle) ? item.line_abs - angle : angle - item.line_abs;
    close = (gap <= bla_pkg::QUARTER_TURN) || (gap >= bla_pkg::REFLEX_LIMIT);
    line_opp = (item.line_abs >= bla_pkg::HALF_TURN) ?
               item.line_abs - bla_pkg::HALF_TURN : item.line_abs + bla_pkg::HALF_TURN;
  end

  always_comb begin
    on_field_next   = on_field;
    angle_next      = angle;
    line_state_next = line_state;
    if (on_field) begin
      if (item.seen) begin
        angle_next      = item.line_abs;
        line_state_next = bla_pkg::LS_TOUCHING;
        on_field_next   = 1'b0;
      end
    end else if (line_state == bla_pkg::LS_OUT) begin
      if (item.seen) begin
        angle_next      = line_opp;
        line_state_next = bla_pkg::LS_OVER;
      end
    end else if (!item.seen) begin
      if (line_state == bla_pkg::LS_TOUCHING) begin
        on_field_next   = 1'b1;
        angle_next      = '0;
        line_state_next = bla_pkg::LS_ON_FIELD;
      end else begin
        line_state_next = bla_pkg::LS_OUT;
      end
    end else if (close) begin
      angle_next      = item.line_abs;
      line_state_next = bla_pkg::LS_TOUCHING;
    end else begin
      angle_next      = line_opp;
      line_state_next = bla_pkg::LS_OVER;
    end
  end

  always_comb begin
    flip = (angle_next >= bla_pkg::HALF_TURN) ?
           angle_next - bla_pkg::HALF_TURN : angle_next + bla_pkg::HALF_TURN;
    if (flip >= item.heading) begin
      away_sum = {1'b0, flip - item.heading};
    end else begin
      away_sum = {1'b0, flip} + {1'b0, bla_pkg::FULL_TURN} - {1'b0, item.heading};
    end
    away = away_sum[8:0];
    diff = (away >= angle_next) ? away - angle_next : angle_next - away;
    near = diff < bla_pkg::NEAR_LIMIT;
  end

  always_comb begin
    result_next.move_direction = item.proposed_direction;
    result_next.move_speed     = item.proposed_speed;
    result_next.inside_field   = on_field_next;
    result_next.crossing_state = line_state_next;
    if (item.seen || line_state_next == bla_pkg::LS_OUT) begin
      result_next.move_direction = away;
      if (item.seen && line_state_next == bla_pkg::LS_TOUCHING) begin
        if (near) begin
          result_next.move_speed = '0;
        end
      end else if (line_state_next == bla_pkg::LS_OVER ||
                   line_state_next == bla_pkg::LS_OUT) begin
        result_next.move_speed = near ? slow_speed : fast_speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_field   <= 1'b1;
      angle      <= '0;
      line_state <= bla_pkg::LS_ON_FIELD;
    end else if (load) begin
      on_field   <= on_field_next;
      angle      <= angle_next;
      line_state <= line_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_on_field_state: assert property (@(posedge clk) disable iff (rst)
    on_field |-> line_state == bla_pkg::LS_ON_FIELD)
    else $error("on-field flag set outside on-field state");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle < bla_pkg::FULL_TURN)
    else $error("remembered line angle out of range");

  a_first_touch: assert property (@(posedge clk) disable iff (rst)
    load && item.seen && on_field |=> !on_field && line_state == bla_pkg::LS_TOUCHING)
    else $error("line sighting on field did not move to touching");

  a_dir_range: assert property (@(posedge clk) disable iff (rst)
    load |=> result.move_direction < bla_pkg::FULL_TURN)
    else $error("move direction out of range");
`endif

endmodule

[tb/tb_top.sv]
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int PHASE_ITEMS = 230;

  class move_predictor;
    bla_pkg::bla_result_t pending_moves[$];
    bla_pkg::speed_t slow_speed;
    bla_pkg::speed_t fast_speed;
    bit on_field;
    int angle;
    bla_pkg::line_state_t crossing;
    int errors;
    int beats_in;
    int state_hits[4];

    function new();
      slow_speed = '0;
      fast_speed = '0;
      on_field = 1'b1;
      angle = 0;
      crossing = bla_pkg::LS_ON_FIELD;
      errors = 0;
      beats_in = 0;
      foreach (state_hits[i]) state_hits[i] = 0;
    endfunction

    function void predict_move(logic seen, logic [bla_pkg::IN_DATA_W-1:0] d);
      int ldir, head, pdir, labs, away, span, mdir, mspd;
      bit near;
      bla_pkg::bla_result_t r;
      ldir = int'(d[8:0]);
      head = int'(d[17:9]) % int'(bla_pkg::FULL_TURN);
      pdir = int'(d[26:18]) % int'(bla_pkg::FULL_TURN);
      labs = (ldir + head) % int'(bla_pkg::FULL_TURN);
      if (on_field) begin
        if (seen) begin
          angle = labs;
          crossing = bla_pkg::LS_TOUCHING;
          on_field = 1'b0;
        end
      end else if (crossing == bla_pkg::LS_OUT) begin
        if (seen) begin
          angle = (labs + int'(bla_pkg::HALF_TURN)) % int'(bla_pkg::FULL_TURN);
          crossing = bla_pkg::LS_OVER;
        end
      end else if (!seen) begin
        if (crossing == bla_pkg::LS_TOUCHING) begin
          on_field = 1'b1;
          angle = 0;
          crossing = bla_pkg::LS_ON_FIELD;
        end else begin
          crossing = bla_pkg::LS_OUT;
        end
      end else begin
        span = (labs >= angle) ? labs - angle : angle - labs;
        if (span > int'(bla_pkg::HALF_TURN)) span = int'(bla_pkg::FULL_TURN) - span;
        if (span <= int'(bla_pkg::QUARTER_TURN)) begin
          angle = labs;
          crossing = bla_pkg::LS_TOUCHING;
        end else begin
          angle = (labs + int'(bla_pkg::HALF_TURN)) % int'(bla_pkg::FULL_TURN);
          crossing = bla_pkg::LS_OVER;
        end
      end
      mdir = pdir;
      mspd = int'(d[34:27]);
      if (seen || crossing == bla_pkg::LS_OUT) begin
        away = (angle + int'(bla_pkg::HALF_TURN) + int'(bla_pkg::FULL_TURN) - head) %
               int'(bla_pkg::FULL_TURN);
        near = ((away >= angle) ? away - angle : angle - away) < int'(bla_pkg::NEAR_LIMIT);
        mdir = away;
        if (seen && crossing == bla_pkg::LS_TOUCHING) begin
          if (near) mspd = 0;
        end else if (crossing == bla_pkg::LS_OVER || crossing == bla_pkg::LS_OUT) begin
          mspd = near ? int'(slow_speed) : int'(fast_speed);
        end
      end
      r.move_direction = bla_pkg::angle_t'(mdir);
      r.move_speed = bla_pkg::speed_t'(mspd);
      r.inside_field = on_field;
      r.crossing_state = crossing;
      pending_moves.push_back(r);
      beats_in++;
    endfunction

    function void report(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      end
    endfunction

    function void check_move(logic [bla_pkg::OUT_DATA_W-1:0] d);
      bla_pkg::bla_result_t r;
      if (pending_moves.size() == 0) begin
        errors++;
        $display("%0t: result beat 0x%h with nothing expected", $time, d);
        return;
      end
      r = pending_moves.pop_front();
      state_hits[d[19:18]]++;
      report("move_direction", int'(r.move_direction), int'(d[8:0]));
      report("move_speed", int'(r.move_speed), int'(d[16:9]));
      report("inside_field", int'(r.inside_field), int'(d[17]));
      report("crossing_state", int'(r.crossing_state), int'(d[19:18]));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [bla_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [bla_pkg::OUT_DATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;

  move_predictor pred = new();
  bit src_idle;
  bit snk_idle;
  int hold_requests = 0;
  int hold_served;
  int items_sent;
  int idle_cycles;

  boundary_line_avoidance dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) pred.predict_move(s_tuser, s_tdata);
      if (m_tvalid && m_tready) pred.check_move(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (snk_idle && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(bit seen, int ld, int hd, int pd, int ps);
    s_tvalid <= 1'b1;
    s_tuser <= seen;
    s_tdata <= {5'b0, ps[7:0], pd[8:0], hd[8:0], ld[8:0]};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (src_idle && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic set_speeds(int slow, int fast);
    cfg_we <= 1'b1;
    cfg_index <= bla_pkg::CFG_SLOW_SPEED;
    cfg_data <= slow[7:0];
    @(posedge clk);
    pred.slow_speed = slow[7:0];
    cfg_index <= bla_pkg::CFG_FAST_SPEED;
    cfg_data <= fast[7:0];
    @(posedge clk);
    pred.fast_speed = fast[7:0];
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pred.pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_heading();
    if ($urandom_range(0, 3) == 0) return $urandom_range(150, 210);
    return $urandom_range(0, 511);
  endfunction

  // one pass across the line: sightings around a field angle, then open field, at times more sightings
  task automatic run_crossing();
    int base, hd, ld, jitter;
    base = $urandom_range(0, 359);
    repeat ($urandom_range(1, 6)) begin
      hd = pick_heading();
      jitter = $urandom_range(0, 40) - 20;
      if ($urandom_range(0, 3) == 0) jitter += 180;
      ld = (base + jitter + 720 - hd % 360) % 360;
      if (ld < 152 && $urandom_range(0, 3) == 0) ld += 360;
      send_item(1'b1, ld, hd, $urandom_range(0, 511), $urandom_range(0, 255));
    end
    repeat ($urandom_range(1, 5))
      send_item(1'b0, $urandom_range(0, 511), pick_heading(), $urandom_range(0, 511),
                $urandom_range(0, 255));
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3))
        send_item(1'b1, $urandom_range(0, 511), pick_heading(), $urandom_range(0, 511),
                  $urandom_range(0, 255));
  endtask

  task automatic run_random(int count, bit last_part);
    int start, mark;
    start = items_sent;
    mark = items_sent;
    while (items_sent - start < count) begin
      if (!last_part && items_sent - mark >= 50) begin
        mark = items_sent;
        src_idle = $urandom_range(0, 2) != 0;
        snk_idle = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 9) < 7) begin
        run_crossing();
      end else begin
        send_item($urandom_range(0, 1) != 0, $urandom_range(0, 511), $urandom_range(0, 511),
                  $urandom_range(0, 511), $urandom_range(0, 255));
      end
    end
  endtask

  initial begin
    int slow_list[6];
    int fast_list[6];
    items_sent = 0;
    idle_cycles = 0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    slow_list = '{0, 255, 0, 255, $urandom_range(1, 254), $urandom_range(0, 255)};
    fast_list = '{0, 255, 255, 0, $urandom_range(1, 254), $urandom_range(0, 255)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_speeds(40, 200);

    send_item(1'b0, 0, 0, 0, 0);
    send_item(1'b0, 511, 511, 511, 255);
    send_item(1'b1, 0, 180, 17, 99);
    send_item(1'b1, 10, 180, 300, 88);
    send_item(1'b1, 359, 0, 5, 77);
    send_item(1'b0, 0, 0, 45, 66);
    send_item(1'b0, 0, 180, 90, 55);
    send_item(1'b1, 0, 0, 135, 44);
    send_item(1'b1, 90, 0, 180, 33);
    send_item(1'b1, 181, 0, 225, 22);
    send_item(1'b0, 0, 0, 270, 11);
    send_item(1'b0, 0, 90, 359, 1);
    send_item(1'b1, 1, 0, 360, 128);
    send_item(1'b1, 91, 0, 400, 127);
    send_item(1'b0, 0, 0, 450, 200);
    send_item(1'b1, 360, 359, 10, 201);
    send_item(1'b1, 511, 511, 20, 202);
    send_item(1'b0, 0, 0, 30, 203);
    send_item(1'b1, 350, 0, 40, 204);
    send_item(1'b1, 10, 0, 50, 205);
    send_item(1'b0, 0, 0, 60, 206);
    send_item(1'b1, 0, 121, 70, 207);
    send_item(1'b1, 1, 120, 80, 208);
    send_item(1'b0, 0, 0, 90, 209);
    drain();

    for (int p = 0; p < 6; p++) begin
      set_speeds(slow_list[p], fast_list[p]);
      if (p == 1) begin
        // stall the output while the input keeps offering beats
        src_idle = 1'b0;
        snk_idle = 1'b0;
        hold_requests <= hold_requests + 1;
      end
      if (p == 5) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end
      run_random(PHASE_ITEMS, p == 5);
      drain();
    end

    $display("Covered %0d input beats over 7 speed settings, with random gaps and one long stall",
             pred.beats_in);
    $display("Results by crossing state: on field %0d, touching %0d, over %0d, out %0d",
             pred.state_hits[0], pred.state_hits[1], pred.state_hits[2], pred.state_hits[3]);
    if (pred.errors == 0 && pred.pending_moves.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never arrived", pred.errors,
               pred.pending_moves.size());
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
